>>> sv/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 16;
  localparam int unsigned CAP_W           = 5;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_RESP
  } state_t;

endpackage

>>> sv/lkvc_ram.sv
// Simple dual-port entry memory with one write port and a registered read port.
module lkvc_ram #(
  parameter int unsigned DEPTH = lkvc_pkg::ENTRIES_DEFAULT,
  parameter int unsigned WIDTH = 68
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/lkvc_engine.sv
// Lookup, replacement and recency update sequencer around the entry memory.
module lkvc_engine #(
  parameter int unsigned ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [$clog2(ENTRIES+1)-1:0] eff_cap,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lkvc_pkg::req_t               in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lkvc_pkg::rsp_t               out_data
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned RW = IW;
  localparam int unsigned CW = $clog2(ENTRIES+1);
  localparam int unsigned WW = 64 + RW;
  localparam logic [IW:0] LAST = (IW+1)'(ENTRIES);

  lkvc_pkg::state_t state_r, state_nxt;
  lkvc_pkg::req_t   req_r, req_nxt;
  lkvc_pkg::rsp_t   rsp_r, rsp_nxt;
  lkvc_pkg::rsp_t   out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [IW:0]         cnt_r, cnt_nxt;
  logic                chk_r, chk_nxt;
  logic [IW-1:0]       chk_idx_r, chk_idx_nxt;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [CW-1:0]       held_r, held_nxt;

  logic                hit_r, hit_nxt;
  logic [IW-1:0]       hit_idx_r, hit_idx_nxt;
  logic [RW-1:0]       hit_rank_r, hit_rank_nxt;
  logic [31:0]         hit_val_r, hit_val_nxt;
  logic                lru_vld_r, lru_vld_nxt;
  logic [IW-1:0]       lru_idx_r, lru_idx_nxt;
  logic [RW-1:0]       lru_rank_r, lru_rank_nxt;
  logic [31:0]         lru_key_r, lru_key_nxt;
  logic                free_vld_r, free_vld_nxt;
  logic [IW-1:0]       free_idx_r, free_idx_nxt;

  logic [IW-1:0]       tgt_r, tgt_nxt;
  logic [RW-1:0]       old_r, old_nxt;
  logic                age_all_r, age_all_nxt;
  logic                kv_r, kv_nxt;

  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [WW-1:0]       mem_wdata;
  logic [IW-1:0]       mem_raddr;
  logic [WW-1:0]       mem_rdata;
  logic [31:0]         rd_key;
  logic [31:0]         rd_val;
  logic [RW-1:0]       rd_rank;
  logic                is_put;

  lkvc_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (WW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_key  = mem_rdata[WW-1 -: 32];
  assign rd_val  = mem_rdata[RW +: 32];
  assign rd_rank = mem_rdata[RW-1:0];
  assign is_put  = (req_r.req_type == lkvc_pkg::REQ_PUT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lkvc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lkvc_pkg::ST_SCAN;
      end
      lkvc_pkg::ST_SCAN: begin
        if (cnt_r == LAST) state_nxt = lkvc_pkg::ST_DECIDE;
      end
      lkvc_pkg::ST_DECIDE: begin
        if (hit_r || is_put) state_nxt = lkvc_pkg::ST_UPDATE;
        else state_nxt = lkvc_pkg::ST_RESP;
      end
      lkvc_pkg::ST_UPDATE: begin
        if (cnt_r == LAST) state_nxt = lkvc_pkg::ST_RESP;
      end
      lkvc_pkg::ST_RESP: begin
        if (!out_valid_r || !out_stall) state_nxt = lkvc_pkg::ST_IDLE;
      end
      default: state_nxt = lkvc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_nxt       = req_r;
    rsp_nxt       = rsp_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    cnt_nxt       = cnt_r;
    chk_nxt       = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    valid_nxt     = valid_r;
    held_nxt      = held_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_rank_nxt  = hit_rank_r;
    hit_val_nxt   = hit_val_r;
    lru_vld_nxt   = lru_vld_r;
    lru_idx_nxt   = lru_idx_r;
    lru_rank_nxt  = lru_rank_r;
    lru_key_nxt   = lru_key_r;
    free_vld_nxt  = free_vld_r;
    free_idx_nxt  = free_idx_r;
    tgt_nxt       = tgt_r;
    old_nxt       = old_r;
    age_all_nxt   = age_all_r;
    kv_nxt        = kv_r;
    mem_we        = 1'b0;
    mem_waddr     = chk_idx_r;
    mem_wdata     = mem_rdata;
    mem_raddr     = cnt_r[IW-1:0];
    in_stall      = (state_r != lkvc_pkg::ST_IDLE);

    unique case (state_r)
      lkvc_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt      = in_data;
          cnt_nxt      = '0;
          hit_nxt      = 1'b0;
          lru_vld_nxt  = 1'b0;
          free_vld_nxt = 1'b0;
        end
      end
      lkvc_pkg::ST_SCAN: begin
        if (cnt_r != LAST) begin
          cnt_nxt     = cnt_r + (IW+1)'(1);
          chk_nxt     = 1'b1;
          chk_idx_nxt = cnt_r[IW-1:0];
        end
        if (chk_r) begin
          if (valid_r[chk_idx_r]) begin
            if (!hit_r && rd_key == req_r.key) begin
              hit_nxt      = 1'b1;
              hit_idx_nxt  = chk_idx_r;
              hit_rank_nxt = rd_rank;
              hit_val_nxt  = rd_val;
            end
            if (!lru_vld_r || rd_rank > lru_rank_r) begin
              lru_vld_nxt  = 1'b1;
              lru_idx_nxt  = chk_idx_r;
              lru_rank_nxt = rd_rank;
              lru_key_nxt  = rd_key;
            end
          end else if (!free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
        end
      end
      lkvc_pkg::ST_DECIDE: begin
        cnt_nxt     = '0;
        rsp_nxt     = '0;
        age_all_nxt = 1'b0;
        kv_nxt      = 1'b1;
        if (hit_r) begin
          rsp_nxt.found = 1'b1;
          if (!is_put) rsp_nxt.read_value = hit_val_r;
          tgt_nxt = hit_idx_r;
          old_nxt = hit_rank_r;
          kv_nxt  = is_put;
        end else if (is_put) begin
          if (held_r < eff_cap && free_vld_r) begin
            tgt_nxt              = free_idx_r;
            age_all_nxt          = 1'b1;
            valid_nxt[free_idx_r] = 1'b1;
            held_nxt             = held_r + CW'(1);
          end else begin
            rsp_nxt.evicted     = 1'b1;
            rsp_nxt.evicted_key = lru_key_r;
            tgt_nxt             = lru_idx_r;
            old_nxt             = lru_rank_r;
          end
        end
      end
      lkvc_pkg::ST_UPDATE: begin
        if (cnt_r != LAST) begin
          cnt_nxt     = cnt_r + (IW+1)'(1);
          chk_nxt     = 1'b1;
          chk_idx_nxt = cnt_r[IW-1:0];
        end
        if (chk_r) begin
          if (chk_idx_r == tgt_r) begin
            mem_we    = 1'b1;
            mem_wdata = {kv_r ? req_r.key : rd_key, kv_r ? req_r.value : rd_val, {RW{1'b0}}};
          end else if (valid_r[chk_idx_r] && (age_all_r || rd_rank < old_r)) begin
            mem_we    = 1'b1;
            mem_wdata = {rd_key, rd_val, rd_rank + RW'(1)};
          end
        end
      end
      lkvc_pkg::ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rsp_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkvc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      held_r      <= '0;
      chk_r       <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      held_r      <= held_nxt;
      chk_r       <= chk_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    rsp_r       <= rsp_nxt;
    out_data_r  <= out_data_nxt;
    chk_idx_r   <= chk_idx_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_rank_r  <= hit_rank_nxt;
    hit_val_r   <= hit_val_nxt;
    lru_vld_r   <= lru_vld_nxt;
    lru_idx_r   <= lru_idx_nxt;
    lru_rank_r  <= lru_rank_nxt;
    lru_key_r   <= lru_key_nxt;
    free_vld_r  <= free_vld_nxt;
    free_idx_r  <= free_idx_nxt;
    tgt_r       <= tgt_nxt;
    old_r       <= old_nxt;
    age_all_r   <= age_all_nxt;
    kv_r        <= kv_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
// Requests enter on in_valid/in_stall/in_data: a get or a put of a 32-bit key,
// with a value for puts. Each request returns exactly one item on
// out_valid/out_stall/out_data with found, read_value, evicted and evicted_key.
// The capacity register is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, as the block does not enforce this. Zero acts as
// one and values above ENTRIES act as ENTRIES. Keys, values and recency ranks
// live in one entry memory with a registered read. A request scans every entry
// to find the hit, the least recent entry and the lowest free slot, then a second
// pass rewrites ranks and the target. A get miss skips the second pass; every
// other request makes both passes.
// One request is in work at a time; the next one is accepted once the current
// result sits in the output register, even if the receiver still stalls it.
// A stalled result holds until taken, and a further finished result waits.
// Reset empties the cache, sets capacity to 16 and drops any pending result.
module lru_key_value_cache #(
  parameter int unsigned ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lkvc_pkg::req_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lkvc_pkg::rsp_t                 out_data
);

  localparam int unsigned CW = $clog2(ENTRIES+1);

  logic [lkvc_pkg::CAP_W-1:0] cfg_capacity_r;
  logic [CW-1:0]              eff_cap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_capacity_r <= lkvc_pkg::CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      cfg_capacity_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (cfg_capacity_r == '0) begin
      eff_cap = CW'(1);
    end else if (32'(cfg_capacity_r) > 32'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = CW'(cfg_capacity_r);
    end
  end

  lkvc_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_cap   (eff_cap),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> dv/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LRU key-value cache, with its own LRU predictor and checker.
module lru_key_value_cache_tb;

  localparam int unsigned SLOTS       = lkvc_pkg::ENTRIES_DEFAULT;
  localparam int unsigned RSP_LATENCY = 2 * SLOTS + 7;
  localparam int unsigned CFG_W       = lkvc_pkg::CAP_W;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  logic             in_valid = 1'b0;
  logic             in_stall;
  lkvc_pkg::req_t   in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  lkvc_pkg::rsp_t   out_data;

  lru_key_value_cache #(.ENTRIES(SLOTS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  bit               line_valid [SLOTS];
  logic [31:0]      line_key   [SLOTS];
  logic [31:0]      line_value [SLOTS];
  int unsigned      line_age   [SLOTS];
  int unsigned      lines_held = 0;
  logic [CFG_W-1:0] capacity_reg = lkvc_pkg::CAPACITY_RESET;

  logic [31:0] corner_keys [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

  lkvc_pkg::req_t req_backlog [$];
  lkvc_pkg::rsp_t rsp_due [$];
  logic [31:0]    key_pool [$];
  int unsigned    reqs_sent = 0;
  int unsigned    send_gap = 0;
  int unsigned    stall_left = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    errors = 0;
  int unsigned    reqs_taken = 0;
  int unsigned    rsps_seen = 0;
  int unsigned    hits_seen = 0;
  int unsigned    evictions_seen = 0;
  int unsigned    settings_used = 1;

  function automatic void make_recent(int s);
    int unsigned old_age;
    old_age = line_age[s];
    for (int i = 0; i < SLOTS; i++) begin
      if (line_valid[i] && i != s && line_age[i] < old_age) begin
        line_age[i]++;
      end
    end
    line_age[s] = 0;
  endfunction

  function automatic lkvc_pkg::rsp_t lru_predict(lkvc_pkg::req_t r);
    lkvc_pkg::rsp_t rsp;
    int             hit;
    int             slot;
    int unsigned    cap;
    int unsigned    oldest;
    rsp  = '0;
    hit  = -1;
    slot = -1;
    cap  = (capacity_reg == 0) ? 1 : (capacity_reg > SLOTS) ? SLOTS : capacity_reg;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && line_valid[i] && line_key[i] == r.key) begin
        hit = i;
      end
    end
    if (hit >= 0) begin
      rsp.found = 1'b1;
      if (r.req_type == lkvc_pkg::REQ_PUT) begin
        line_value[hit] = r.value;
      end else begin
        rsp.read_value = line_value[hit];
      end
      make_recent(hit);
    end else if (r.req_type == lkvc_pkg::REQ_PUT) begin
      if (lines_held < cap) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && !line_valid[i]) begin
            slot = i;
          end
        end
      end
      if (slot >= 0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (line_valid[i]) begin
            line_age[i]++;
          end
        end
        line_valid[slot] = 1'b1;
        lines_held++;
      end else begin
        oldest = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (line_valid[i] && (slot < 0 || line_age[i] > oldest)) begin
            slot   = i;
            oldest = line_age[i];
          end
        end
        rsp.evicted     = 1'b1;
        rsp.evicted_key = line_key[slot];
        make_recent(slot);
      end
      line_key[slot]   = r.key;
      line_value[slot] = r.value;
      line_age[slot]   = 0;
    end
    return rsp;
  endfunction

  function automatic int unsigned pick_gap(int unsigned pct);
    if ($urandom_range(99) >= pct) begin
      return 0;
    end
    if ($urandom_range(9) == 0) begin
      return $urandom_range(60, 12);
    end
    return $urandom_range(3, 1);
  endfunction

  task automatic flag_mismatch(string msg);
    errors++;
    $display("lru_key_value_cache_tb: mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic queue_req(logic kind, logic [31:0] key, logic [31:0] value);
    lkvc_pkg::req_t r;
    r.req_type = kind;
    r.key      = key;
    r.value    = value;
    req_backlog = {req_backlog, r};
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || rsp_due.size() != 0);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] cap);
    wait_idle();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    if (reqs_taken == reqs_sent) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        in_data  <= req_backlog[0];
        req_backlog.delete(0);
        in_valid <= 1'b1;
        reqs_sent++;
        send_gap = pick_gap(send_idle_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap(recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    lkvc_pkg::rsp_t want;
    if (rst_n) begin
      if (cfg_wr_en) begin
        capacity_reg = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        want = lru_predict(in_data);
        hits_seen      += want.found;
        evictions_seen += want.evicted;
        rsp_due = {rsp_due, want};
        reqs_taken++;
      end
      if (out_valid && !out_stall) begin
        rsps_seen++;
        if (rsp_due.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with no request outstanding", rsps_seen));
        end else begin
          want = rsp_due[0];
          rsp_due.delete(0);
          if (out_data.found !== want.found) begin
            flag_mismatch($sformatf("result %0d found %b, predicted %b",
                                    rsps_seen, out_data.found, want.found));
          end
          if (out_data.read_value !== want.read_value) begin
            flag_mismatch($sformatf("result %0d read_value %h, predicted %h",
                                    rsps_seen, out_data.read_value, want.read_value));
          end
          if (out_data.evicted !== want.evicted) begin
            flag_mismatch($sformatf("result %0d evicted %b, predicted %b",
                                    rsps_seen, out_data.evicted, want.evicted));
          end
          if (out_data.evicted_key !== want.evicted_key) begin
            flag_mismatch($sformatf("result %0d evicted_key %h, predicted %h",
                                    rsps_seen, out_data.evicted_key, want.evicted_key));
          end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("lru_key_value_cache_tb: timed out with %0d results outstanding", rsp_due.size());
    $display("lru_key_value_cache_tb: done, errors");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] cap;
    int unsigned      pool_size;
    logic [31:0]      key;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // An empty cache, then the key and value extremes at the reset capacity.
    recv_idle_pct = 30;
    queue_req(lkvc_pkg::REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_req(lkvc_pkg::REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_req(lkvc_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_req(lkvc_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(lkvc_pkg::REQ_PUT, 32'h0000_0000, 32'h0000_0000);
    queue_req(lkvc_pkg::REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_req(lkvc_pkg::REQ_GET, 32'h8000_0000, 32'h0000_0000);
    queue_req(lkvc_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_req(lkvc_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(lkvc_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0005);
    queue_req(lkvc_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_req(lkvc_pkg::REQ_GET, 32'h0001_2345, 32'h0000_0000);

    // Capacity dropped below the number of entries held: new keys replace the oldest.
    write_capacity(5'd2);
    queue_req(lkvc_pkg::REQ_PUT, 32'h0000_0001, 32'hAAAA_AAAA);
    queue_req(lkvc_pkg::REQ_PUT, 32'h0000_0002, 32'h5555_5555);
    queue_req(lkvc_pkg::REQ_GET, 32'h8000_0000, 32'h0000_0000);
    queue_req(lkvc_pkg::REQ_GET, 32'h0000_0001, 32'h0000_0000);

    // A zero capacity acts as one.
    write_capacity(5'd0);
    queue_req(lkvc_pkg::REQ_PUT, 32'h0000_0003, 32'h0000_0003);
    queue_req(lkvc_pkg::REQ_GET, 32'h0000_0002, 32'h0000_0000);

    // A capacity beyond the entry count acts as the entry count.
    write_capacity(5'd31);
    queue_req(lkvc_pkg::REQ_PUT, 32'h0000_0004, 32'h0000_0004);
    queue_req(lkvc_pkg::REQ_PUT, 32'h0000_0005, 32'h0000_0005);

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin
          cap = 5'd31;
        end
        1: begin
          cap = 5'd1;
        end
        2: begin
          cap = 5'd16;
        end
        3: begin
          cap = 5'd0;
        end
        4: begin
          cap = 5'd17;
        end
        default: begin
          cap = CFG_W'($urandom_range(16, 1));
        end
      endcase
      write_capacity(cap);
      send_idle_pct = (p % 4) * 20;
      recv_idle_pct = ((p * 3) % 4) * 20;
      pool_size = ((cap > SLOTS) ? SLOTS : cap) + $urandom_range(4, 1);
      key_pool.delete();
      for (int k = 0; k < pool_size; k++) begin
        if ($urandom_range(7) == 0) begin
          key_pool = {key_pool, corner_keys[$urandom_range(3)]};
        end else begin
          key_pool = {key_pool, 32'($urandom)};
        end
      end
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(99) < 80) begin
          key = key_pool[$urandom_range(key_pool.size() - 1)];
        end else begin
          key = $urandom;
        end
        queue_req($urandom_range(1) ? lkvc_pkg::REQ_PUT : lkvc_pkg::REQ_GET, key, $urandom);
      end
    end

    wait_idle();
    repeat (RSP_LATENCY + 8) @(negedge clk);
    $display("Covered %0d requests over %0d capacity settings: %0d hits, %0d evictions.",
             reqs_taken, settings_used, hits_seen, evictions_seen);
    $display("Checked %0d results against the predictor, %0d mismatches.", rsps_seen, errors);
    if (errors == 0) begin
      $display("lru_key_value_cache_tb: done, clean");
    end else begin
      $display("lru_key_value_cache_tb: done, errors");
    end
    $finish;
  end

endmodule
